// ===== rtl/texture_sample_address_and_weights_core_macros.svh =====
// Assertion macros for the texture sample addressing core.
// Used by the RTL files that carry concurrent checks; depends on nothing else.
`ifndef TEXTURE_SAMPLE_ADDRESS_AND_WEIGHTS_CORE_MACROS_SVH
`define TEXTURE_SAMPLE_ADDRESS_AND_WEIGHTS_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define TSAW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is held.
`define TSAW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define TSAW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSAW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/texsaw_pkg.sv =====
// Shared types, codes and helpers of the texture sample addressing core.
// No dependencies; imported by texsaw_axis and the top level.
package texsaw_pkg;

  // Register indexes of the configuration port
  localparam int            CFG_IDX_W         = 3;
  localparam int            CFG_DATA_W        = 13;
  localparam logic [2:0]    REG_ADDRESS_MODE  = 3'd0;
  localparam logic [2:0]    REG_FILTER_MODE   = 3'd1;
  localparam logic [2:0]    REG_MIPMAP_MODE   = 3'd2;
  localparam logic [2:0]    REG_TEX_WIDTH     = 3'd3;
  localparam logic [2:0]    REG_TEX_HEIGHT    = 3'd4;
  localparam logic [2:0]    REG_MAX_MIP_LEVEL = 3'd5;

  // Default parameter values
  localparam int UV_FRAC_BITS_DEF = 16;
  localparam int TEX_DIM_BITS_DEF = 12;

  // Fixed field widths
  localparam int COORD_W  = 24;
  localparam int TEXEL_W  = 12;
  localparam int LEVEL_W  = 4;
  localparam int WEIGHT_W = 17;
  localparam int TDIM_W   = 13;

  localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'h10000;

  typedef enum logic [1:0] {
    ADDR_REPEAT = 2'd0,
    ADDR_MIRROR = 2'd1,
    ADDR_CLAMP  = 2'd2,
    ADDR_BORDER = 2'd3
  } addr_mode_t;

  localparam logic [1:0] MIP_BASE    = 2'd0;
  localparam logic [1:0] MIP_NEAREST = 2'd1;
  localparam logic [1:0] MIP_BLEND   = 2'd2;

  // Control into one axis unit
  typedef struct packed {
    logic wrap;
    logic bilinear;
  } axis_ctl_t;

  // Result of one axis unit
  typedef struct packed {
    logic [TEXEL_W-1:0]  i0;
    logic [TEXEL_W-1:0]  i1;
    logic [WEIGHT_W-1:0] w;
  } axis_res_t;

  // Convert a weight with frac fraction bits to Q1.16
  function automatic logic [WEIGHT_W-1:0] to_q16(logic [47:0] w, int frac);
    logic [47:0] t;
    t = (w << ((frac < 16) ? (16 - frac) : 0)) >> ((frac >= 16) ? (frac - 16) : 0);
    return WEIGHT_W'(t);
  endfunction

endpackage

// ===== rtl/texsaw_axis.sv =====
// One texture axis: texel pair and weight at one level for point or bilinear.
// Depends on texsaw_pkg for the control and result structs and to_q16.
module texsaw_axis #(
  parameter int UV_FRAC_BITS = texsaw_pkg::UV_FRAC_BITS_DEF,
  parameter int TEX_DIM_BITS = texsaw_pkg::TEX_DIM_BITS_DEF
) (
  input  logic [UV_FRAC_BITS:0]   coord,
  input  logic [TEX_DIM_BITS:0]   size,
  input  texsaw_pkg::axis_ctl_t   ctl,
  output texsaw_pkg::axis_res_t   res
);
  import texsaw_pkg::*;

  localparam int UV = UV_FRAC_BITS;
  localparam int DW = TEX_DIM_BITS + 1;
  localparam int PW = UV + 1 + DW;
  localparam logic [UV:0]   ONE      = {1'b1, {UV{1'b0}}};
  localparam logic [UV-1:0] HALF     = {1'b1, {(UV-1){1'b0}}};
  localparam logic [UV:0]   ONE_HALF = {2'b11, {(UV-1){1'b0}}};

  logic [PW-1:0] prod;
  logic [DW:0]   k;
  logic [UV-1:0] r;
  logic [DW:0]   nm1;
  logic [DW:0]   i0;
  logic [DW:0]   i1;
  logic [UV:0]   wraw;
  logic          full;

  // Scale the coordinate by the level size
  assign prod = PW'(coord) * PW'(size);
  assign k    = prod[PW-1:UV];
  assign r    = prod[UV-1:0];
  assign nm1  = (DW + 1)'(size) - 1'b1;

  always_comb begin
    full = 1'b0;
    wraw = '0;
    i0   = k;
    i1   = k;
    if (!ctl.bilinear) begin
      // Point: nearest texel, limited to the last one
      full = 1'b1;
      i0   = (k > nm1) ? nm1 : k;
      i1   = i0;
    end else if (coord >= ONE) begin
      // Right or bottom edge: last texel alone
      full = 1'b1;
      i0   = nm1;
      i1   = nm1;
    end else if (r < HALF) begin
      // Left half of the texel: pair with the previous one
      wraw = (UV + 1)'(HALF - r);
      i1   = k;
      if (ctl.wrap && k == '0) begin
        i0 = nm1;
      end else begin
        i0 = (k != '0) ? k - 1'b1 : '0;
      end
    end else begin
      // Right half: pair with the next one
      wraw = ONE_HALF - (UV + 1)'(r);
      i0   = k;
      if (ctl.wrap && k == nm1) begin
        i1 = '0;
      end else begin
        i1 = (k + 1'b1 > nm1) ? nm1 : k + 1'b1;
      end
    end
  end

  assign res.i0 = TEXEL_W'(i0);
  assign res.i1 = TEXEL_W'(i1);
  assign res.w  = full ? Q16_ONE : to_q16(48'(wraw), UV);

endmodule

// ===== rtl/texture_sample_address_and_weights_core.sv =====
// Top level of the texture sample addressing core: registers, address mapping,
// mip selection and result stage. Depends on texsaw_pkg, texsaw_axis, macros.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | slave     | in_tvalid/tready   | in_tdata: u, v, ddx_u, ddy_v
//  out_    | master    | out_tvalid/tready  | out_tdata, out_tuser, out_tlast
//  cfg_    | write     | cfg_we             | cfg_index, cfg_data
//
// Three register stages: input, scale (after the derivative multipliers) and
// result (after the per-axis multipliers). One request per cycle in base and
// nearest mip modes unless the output stalls; in blend mode the scale stage
// emits two results (one for a border) and takes the next request after both.
// Reset is synchronous and clears the valid flags and config registers. A
// stalled output holds its result; earlier stages fill until full, then hold.
module texture_sample_address_and_weights_core #(
  parameter int UV_FRAC_BITS = texsaw_pkg::UV_FRAC_BITS_DEF,
  parameter int TEX_DIM_BITS = texsaw_pkg::TEX_DIM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [texsaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [texsaw_pkg::CFG_DATA_W-1:0] cfg_data,
  // requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // u_coord[23:0], v_coord[47:24], ddx_u[71:48], ddy_v[95:72]
  input  logic [95:0]                       in_tdata,
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // texel_x0[11:0], texel_x1[23:12], texel_y0[35:24], texel_y1[47:36],
  // mip_level[51:48], weight_u[68:52], weight_v[85:69], mip_weight[102:86], zero
  output logic [103:0]                      out_tdata,
  // use_border[0]
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import texsaw_pkg::*;

`include "texture_sample_address_and_weights_core_macros.svh"

  localparam int UV  = UV_FRAC_BITS;
  localparam int DW  = TEX_DIM_BITS + 1;
  localparam int CW  = ((UV + 3) > 26) ? (UV + 3) : 26;
  localparam int PW  = COORD_W + DW + 1;
  localparam int SW  = PW - 1;
  localparam int KW  = SW - UV;
  localparam int EW  = (TDIM_W > DW) ? TDIM_W : DW;
  localparam int LIM = 1 << TEX_DIM_BITS;
  localparam logic signed [CW-1:0] ONE_S = CW'(1) <<< UV;
  localparam logic [UV:0]          ONE   = {1'b1, {UV{1'b0}}};
  localparam logic [UV-1:0]        HALF  = {1'b1, {(UV-1){1'b0}}};

  // ---------------------------------------------------------------- config
  addr_mode_t          addr_mode_r;
  logic                filter_mode_r;
  logic [1:0]          mipmap_mode_r;
  logic [TDIM_W-1:0]   tex_width_r;
  logic [TDIM_W-1:0]   tex_height_r;
  logic [LEVEL_W-1:0]  max_mip_r;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_mode_r   <= ADDR_REPEAT;
      filter_mode_r <= 1'b0;
      mipmap_mode_r <= MIP_BASE;
      tex_width_r   <= 13'd256;
      tex_height_r  <= 13'd256;
      max_mip_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADDRESS_MODE:  addr_mode_r   <= addr_mode_t'(cfg_data[1:0]);
        REG_FILTER_MODE:   filter_mode_r <= cfg_data[0];
        REG_MIPMAP_MODE:   mipmap_mode_r <= cfg_data[1:0];
        REG_TEX_WIDTH:     tex_width_r   <= cfg_data;
        REG_TEX_HEIGHT:    tex_height_r  <= cfg_data;
        REG_MAX_MIP_LEVEL: max_mip_r     <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate a texture dimension to [1, 2^TEX_DIM_BITS]
  function automatic logic [DW-1:0] sat_dim(logic [TDIM_W-1:0] d);
    logic [EW-1:0] de;
    de = EW'(d);
    if (de == '0) begin
      return DW'(1);
    end else if (de > EW'(LIM)) begin
      return DW'(LIM);
    end
    return DW'(de);
  endfunction

  logic [DW-1:0] wd_sat;
  logic [DW-1:0] ht_sat;
  assign wd_sat = sat_dim(tex_width_r);
  assign ht_sat = sat_dim(tex_height_r);

  // ---------------------------------------------------------------- handshake
  logic a_valid_r;
  logic b_valid_r;
  logic b_phase_r;
  logic out_valid_r;
  logic out_load;
  logic b_last;
  logic b_load;
  logic a_load;

  assign out_load  = b_valid_r && (!out_valid_r || out_tready);
  assign b_load    = a_valid_r && (!b_valid_r || (out_load && b_last));
  assign in_tready = !a_valid_r || b_load;
  assign a_load    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      b_phase_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= 1'b1;
      end else if (b_load) begin
        a_valid_r <= 1'b0;
      end
      if (b_load) begin
        b_valid_r <= 1'b1;
        b_phase_r <= 1'b0;
      end else if (out_load) begin
        b_valid_r <= !b_last;
        b_phase_r <= !b_last;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- input stage
  logic signed [COORD_W-1:0] a_u_r;
  logic signed [COORD_W-1:0] a_v_r;
  logic signed [COORD_W-1:0] a_dx_r;
  logic signed [COORD_W-1:0] a_dy_r;

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_u_r  <= in_tdata[23:0];
      a_v_r  <= in_tdata[47:24];
      a_dx_r <= in_tdata[71:48];
      a_dy_r <= in_tdata[95:72];
    end
  end

  // Out-of-range test for clamp to border
  function automatic logic outside(logic signed [COORD_W-1:0] c);
    logic signed [CW-1:0] ce;
    ce = CW'(c);
    return (ce < 0) || (ce > ONE_S);
  endfunction

  // Map a raw coordinate into [0, ONE] by the address mode
  function automatic logic [UV:0] map_coord(logic signed [COORD_W-1:0] c, addr_mode_t m);
    logic signed [CW-1:0] ce;
    logic [CW-1:0]        mag;
    logic [UV:0]          t;
    logic [UV+1:0]        refl;
    ce   = CW'(c);
    mag  = (ce < 0) ? CW'(-ce) : CW'(ce);
    t    = mag[UV:0];
    refl = {1'b1, {(UV+1){1'b0}}} - (UV + 2)'(t);
    unique case (m)
      ADDR_REPEAT: return {1'b0, ce[UV-1:0]};
      ADDR_MIRROR: return t[UV] ? refl[UV:0] : t;
      default: begin
        if (ce < 0) begin
          return '0;
        end else if (ce > ONE_S) begin
          return ONE;
        end
        return ce[UV:0];
      end
    endcase
  endfunction

  logic                 border_a;
  logic [UV:0]          u_map_a;
  logic [UV:0]          v_map_a;
  logic signed [PW-1:0] sx_a;
  logic signed [PW-1:0] sy_a;
  logic signed [PW-1:0] smax_a;
  logic [SW-1:0]        s_a;

  // Map coordinates and scale the derivatives by the texture size
  assign border_a = (addr_mode_r == ADDR_BORDER) && (outside(a_u_r) || outside(a_v_r));
  assign u_map_a  = map_coord(a_u_r, addr_mode_r);
  assign v_map_a  = map_coord(a_v_r, addr_mode_r);
  assign sx_a     = PW'(a_dx_r) * $signed(PW'(wd_sat));
  assign sy_a     = PW'(a_dy_r) * $signed(PW'(ht_sat));
  assign smax_a   = (sx_a > sy_a) ? sx_a : sy_a;
  assign s_a      = smax_a[PW-1] ? '0 : smax_a[SW-1:0];

  // ---------------------------------------------------------------- scale stage
  logic          b_border_r;
  logic [UV:0]   b_u_r;
  logic [UV:0]   b_v_r;
  logic [SW-1:0] b_s_r;

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_border_r <= border_a;
      b_u_r      <= u_map_a;
      b_v_r      <= v_map_a;
      b_s_r      <= s_a;
    end
  end

  logic [KW-1:0]       k_b;
  logic [UV-1:0]       f_b;
  logic [LEVEL_W-1:0]  lvl_k;
  logic [LEVEL_W-1:0]  lvl_km1;
  logic [LEVEL_W-1:0]  lvl_b;
  logic [WEIGHT_W-1:0] w_lo_b;
  logic [WEIGHT_W-1:0] mw_b;
  logic [DW-1:0]       w_sh;
  logic [DW-1:0]       h_sh;
  logic [DW-1:0]       lvl_w;
  logic [DW-1:0]       lvl_h;

  // Pick the level and the level weight for this result
  assign k_b     = b_s_r[SW-1:UV];
  assign f_b     = b_s_r[UV-1:0];
  assign lvl_k   = (k_b > KW'(max_mip_r)) ? max_mip_r : LEVEL_W'(k_b);
  assign lvl_km1 = (k_b == '0) ? '0 :
                   (k_b > KW'(max_mip_r)) ? max_mip_r : LEVEL_W'(k_b - 1'b1);
  assign w_lo_b  = to_q16(48'(ONE - (UV + 1)'(f_b)), UV);
  assign b_last  = b_border_r || (mipmap_mode_r != MIP_BLEND) || b_phase_r;

  always_comb begin
    unique case (mipmap_mode_r)
      MIP_NEAREST: begin
        lvl_b = (f_b > HALF) ? lvl_k : lvl_km1;
        mw_b  = Q16_ONE;
      end
      MIP_BLEND: begin
        lvl_b = b_phase_r ? lvl_k : lvl_km1;
        mw_b  = b_phase_r ? (Q16_ONE - w_lo_b) : w_lo_b;
      end
      default: begin
        lvl_b = '0;
        mw_b  = Q16_ONE;
      end
    endcase
  end

  // Level size, kept at least one texel
  assign w_sh  = wd_sat >> lvl_b;
  assign h_sh  = ht_sat >> lvl_b;
  assign lvl_w = (w_sh == '0) ? DW'(1) : w_sh;
  assign lvl_h = (h_sh == '0) ? DW'(1) : h_sh;

  axis_ctl_t axis_ctl;
  axis_res_t res_x;
  axis_res_t res_y;

  assign axis_ctl.wrap     = (addr_mode_r == ADDR_REPEAT);
  assign axis_ctl.bilinear = filter_mode_r;

  texsaw_axis #(
    .UV_FRAC_BITS (UV_FRAC_BITS),
    .TEX_DIM_BITS (TEX_DIM_BITS)
  ) u_axis_x (
    .coord (b_u_r),
    .size  (lvl_w),
    .ctl   (axis_ctl),
    .res   (res_x)
  );

  texsaw_axis #(
    .UV_FRAC_BITS (UV_FRAC_BITS),
    .TEX_DIM_BITS (TEX_DIM_BITS)
  ) u_axis_y (
    .coord (b_v_r),
    .size  (lvl_h),
    .ctl   (axis_ctl),
    .res   (res_y)
  );

  // ---------------------------------------------------------------- result stage
  logic [103:0] out_data_r;
  logic [103:0] out_data_nxt;
  logic         out_border_r;
  logic         out_last_r;

  always_comb begin
    if (b_border_r) begin
      out_data_nxt = {1'b0, Q16_ONE, 86'd0};
    end else begin
      out_data_nxt = {1'b0, mw_b, res_y.w, res_x.w, lvl_b,
                      res_y.i1, res_y.i0, res_x.i1, res_x.i0};
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= out_data_nxt;
      out_border_r <= b_border_r;
      out_last_r   <= b_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_border_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- checks
  `TSAW_ASSERT_IMPL(a_border_single, clk, rst_n, out_valid_r && out_border_r, out_last_r)
  `TSAW_ASSERT_IMPL(a_first_only_blend, clk, rst_n, out_valid_r && !out_last_r,
                    mipmap_mode_r == MIP_BLEND)
  `TSAW_ASSERT_IMPL(a_phase_blend, clk, rst_n, b_valid_r && b_phase_r,
                    (mipmap_mode_r == MIP_BLEND) && !b_border_r)
  `TSAW_ASSERT_NEXT(a_second_follows, clk, rst_n, out_load && !b_last,
                    b_valid_r && b_phase_r)
  `TSAW_ASSERT_IMPL(a_mip_weight_max, clk, rst_n, out_valid_r && out_data_r[102],
                    out_data_r[101:86] == 16'd0)

endmodule
